// ----- sv/wsrx_pkg.sv -----
// Shared types and constants for the WebSocket frame receive parser.
// Used by the front classifier, the back parser and the top level.
package wsrx_pkg;

    // Default depth of the queues between the parts of the block
    localparam int unsigned QUEUE_DEPTH = 2;

    // Header field codes
    localparam logic [3:0]  OPC_CLOSE   = 4'h8;
    localparam logic [6:0]  LEN_CODE_16 = 7'd126;
    localparam logic [6:0]  LEN_CODE_64 = 7'd127;
    localparam logic [15:0] MASK_BYTES  = 16'd4;

    // Parse position inside a frame
    typedef enum logic [2:0] {
        PH_HDR0   = 3'd0,
        PH_HDR1   = 3'd1,
        PH_LENHI  = 3'd2,
        PH_LENLO  = 3'd3,
        PH_MASK   = 3'd4,
        PH_DATA   = 3'd5,
        PH_IGNORE = 3'd6
    } t_phase;

    // Result event codes
    typedef enum logic [2:0] {
        EV_PAYLOAD = 3'd0,
        EV_EMPTY   = 3'd1,
        EV_CLOSE   = 3'd2,
        EV_FRAG    = 3'd3,
        EV_NOMASK  = 3'd4,
        EV_LONG    = 3'd5,
        EV_TRUNC   = 3'd6
    } t_event;

    // Input byte with its header classification
    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
        logic [7:0] conn_id;
        logic       is_close;
        logic       top_bit;
        logic       len_is_64;
        logic       len_is_16;
    } t_class_item;

    // One result item
    typedef struct packed {
        t_event     event_kind;
        logic [7:0] payload_byte;
        logic       last_of_message;
        logic [3:0] frame_opcode;
        logic [7:0] out_conn_id;
    } t_result;

endpackage

// ----- sv/wsrx_fifo.sv -----
// Small first-in first-out queue with full and empty flags.
// Generic storage used between the front, the back and the result port.
module wsrx_fifo #(
    parameter int unsigned P_WIDTH = 8,
    parameter int unsigned P_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [P_WIDTH-1:0] i_data,
    input  logic               i_pop,
    output logic [P_WIDTH-1:0] o_data,
    output logic               o_full,
    output logic               o_empty
);

    localparam int unsigned AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CW = $clog2(P_DEPTH + 1);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [AW-1:0]      r_wr_ptr;
    logic [AW-1:0]      r_rd_ptr;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      n_wr_ptr;
    logic [AW-1:0]      n_rd_ptr;
    logic [CW-1:0]      n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- sv/wsrx_front.sv -----
// Front part: accepts received bytes and classifies their header bits.
// Depends on wsrx_pkg; feeds the classified-item queue.
module wsrx_front (
    input  logic                 i_push,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_buffer_end,
    input  logic [7:0]           i_conn_id,
    input  logic                 i_queue_full,
    output logic                 o_full,
    output logic                 o_queue_push,
    output wsrx_pkg::t_class_item o_item
);

    import wsrx_pkg::*;

    // Hand full straight back from the queue
    assign o_full       = i_queue_full;
    assign o_queue_push = i_push && !i_queue_full;

    // Decode the header fields this byte could carry
    always_comb begin
        o_item.data_byte  = i_data_byte;
        o_item.buffer_end = i_buffer_end;
        o_item.conn_id    = i_conn_id;
        o_item.is_close   = (i_data_byte[3:0] == OPC_CLOSE);
        o_item.top_bit    = i_data_byte[7];
        o_item.len_is_64  = (i_data_byte[6:0] == LEN_CODE_64);
        o_item.len_is_16  = (i_data_byte[6:0] == LEN_CODE_16);
    end

endmodule

// ----- sv/wsrx_back.sv -----
// Back part: frame parse state machine, unmasking and event generation.
// Depends on wsrx_pkg; drains the classified-item queue into the result queue.
module wsrx_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  wsrx_pkg::t_class_item i_item,
    input  logic                  i_out_full,
    output logic                  o_pop,
    output logic                  o_push,
    output wsrx_pkg::t_result     o_result
);

    import wsrx_pkg::*;

    t_phase      r_phase;
    t_phase      n_phase;
    t_phase      step_phase;
    logic [3:0]  r_opcode;
    logic [3:0]  n_opcode;
    logic [15:0] r_len;
    logic [15:0] n_len;
    logic [15:0] r_count;
    logic [15:0] n_count;
    logic [31:0] r_mask;
    logic [31:0] n_mask;
    logic [15:0] count_inc;
    logic [7:0]  mask_byte;
    logic        fire;
    logic        have;
    logic        trunc;
    t_event      kind;
    logic [7:0]  pbyte;
    logic        last;

    assign fire      = i_valid && !i_out_full;
    assign o_pop     = fire;
    assign count_inc = r_count + 16'd1;

    // Pick the mask byte for this payload position
    always_comb begin
        case (r_count[1:0])
            2'd0:    mask_byte = r_mask[31:24];
            2'd1:    mask_byte = r_mask[23:16];
            2'd2:    mask_byte = r_mask[15:8];
            default: mask_byte = r_mask[7:0];
        endcase
    end

    // Next phase from the current byte
    always_comb begin
        case (r_phase)
            PH_HDR0: begin
                if (i_item.is_close || !i_item.top_bit) begin
                    step_phase = PH_IGNORE;
                end else begin
                    step_phase = PH_HDR1;
                end
            end
            PH_HDR1: begin
                if (!i_item.top_bit || i_item.len_is_64) begin
                    step_phase = PH_IGNORE;
                end else if (i_item.len_is_16) begin
                    step_phase = PH_LENHI;
                end else begin
                    step_phase = PH_MASK;
                end
            end
            PH_LENHI: step_phase = PH_LENLO;
            PH_LENLO: step_phase = PH_MASK;
            PH_MASK: begin
                if (count_inc >= MASK_BYTES) begin
                    step_phase = (r_len == '0) ? PH_IGNORE : PH_DATA;
                end else begin
                    step_phase = PH_MASK;
                end
            end
            PH_DATA: step_phase = (count_inc == r_len) ? PH_IGNORE : PH_DATA;
            PH_IGNORE: step_phase = PH_IGNORE;
            default: step_phase = r_phase;
        endcase
        trunc   = i_item.buffer_end && (step_phase inside {[PH_HDR0:PH_DATA]});
        n_phase = i_item.buffer_end ? PH_HDR0 : step_phase;
    end

    // Events and field updates for the current byte
    always_comb begin
        have     = 1'b0;
        kind     = EV_PAYLOAD;
        pbyte    = 8'h00;
        last     = 1'b0;
        n_opcode = r_opcode;
        n_len    = r_len;
        n_count  = r_count;
        n_mask   = r_mask;
        case (r_phase)
            PH_HDR0: begin
                n_opcode = i_item.data_byte[3:0];
                if (i_item.is_close) begin
                    have = 1'b1;
                    kind = EV_CLOSE;
                end else if (!i_item.top_bit) begin
                    have = 1'b1;
                    kind = EV_FRAG;
                end
            end
            PH_HDR1: begin
                if (!i_item.top_bit) begin
                    have = 1'b1;
                    kind = EV_NOMASK;
                end else if (i_item.len_is_64) begin
                    have = 1'b1;
                    kind = EV_LONG;
                end else if (!i_item.len_is_16) begin
                    n_len   = {9'd0, i_item.data_byte[6:0]};
                    n_count = '0;
                end
            end
            PH_LENHI: n_len = {i_item.data_byte, 8'h00};
            PH_LENLO: begin
                n_len   = r_len | {8'h00, i_item.data_byte};
                n_count = '0;
            end
            PH_MASK: begin
                n_mask  = {r_mask[23:0], i_item.data_byte};
                n_count = count_inc;
                if (count_inc >= MASK_BYTES) begin
                    n_count = '0;
                    if (r_len == '0) begin
                        have = 1'b1;
                        kind = EV_EMPTY;
                        last = 1'b1;
                    end
                end
            end
            PH_DATA: begin
                have    = 1'b1;
                kind    = EV_PAYLOAD;
                pbyte   = i_item.data_byte ^ mask_byte;
                n_count = count_inc;
                last    = (count_inc == r_len);
            end
            default: begin
            end
        endcase
        // Flag an early buffer end and restart at the header
        if (i_item.buffer_end) begin
            n_count = '0;
            if (trunc) begin
                have  = 1'b1;
                kind  = EV_TRUNC;
                pbyte = 8'h00;
                last  = 1'b0;
            end
        end
    end

    assign o_push                   = fire && have;
    assign o_result.event_kind      = kind;
    assign o_result.payload_byte    = pbyte;
    assign o_result.last_of_message = last;
    assign o_result.frame_opcode    = n_opcode;
    assign o_result.out_conn_id     = i_item.conn_id;

    // Hold parse state, advance on each consumed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_opcode <= '0;
            r_len    <= '0;
            r_count  <= '0;
            r_mask   <= '0;
        end else if (fire) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_len    <= n_len;
            r_count  <= n_count;
            r_mask   <= n_mask;
        end
    end

endmodule

// ----- sv/ws_frame_receive_parser.sv -----
// WebSocket client-to-server frame receive parser. Bytes enter through a
// push/full queue port and results leave through an empty/pop queue port. The
// block takes one byte per clock cycle when results are drained as fast; each
// byte is registered in a classified-item queue, read by the parse state machine,
// and its result registered in the result queue ahead of the result ports. The
// parse state machine consumes one byte a cycle while the result queue has
// room, and sets the rate. Each byte gives at most one result: a payload byte,
// an empty message, or a close, fragmented, no-mask, too-long or truncated event.
module ws_frame_receive_parser #(
    parameter int unsigned P_QUEUE_DEPTH = wsrx_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_buffer_end,
    input  logic [7:0] i_conn_id,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] o_event_kind,
    output logic [7:0] o_payload_byte,
    output logic       o_last_of_message,
    output logic [3:0] o_frame_opcode,
    output logic [7:0] o_out_conn_id
);

    import wsrx_pkg::*;

    t_class_item front_item;
    t_class_item cq_head;
    logic        cq_push;
    logic        cq_pop;
    logic        cq_full;
    logic        cq_empty;
    t_result     back_result;
    t_result     out_head;
    logic        outq_push;
    logic        outq_full;

    // Classify incoming bytes
    wsrx_front u_front (
        .i_push       (push),
        .i_data_byte  (i_data_byte),
        .i_buffer_end (i_buffer_end),
        .i_conn_id    (i_conn_id),
        .i_queue_full (cq_full),
        .o_full       (full),
        .o_queue_push (cq_push),
        .o_item       (front_item)
    );

    // Queue classified items between front and back
    wsrx_fifo #(
        .P_WIDTH ($bits(t_class_item)),
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_class_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cq_push),
        .i_data  (front_item),
        .i_pop   (cq_pop),
        .o_data  (cq_head),
        .o_full  (cq_full),
        .o_empty (cq_empty)
    );

    // Parse frames and build results
    wsrx_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!cq_empty),
        .i_item     (cq_head),
        .i_out_full (outq_full),
        .o_pop      (cq_pop),
        .o_push     (outq_push),
        .o_result   (back_result)
    );

    // Hold results until popped
    wsrx_fifo #(
        .P_WIDTH ($bits(t_result)),
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (outq_push),
        .i_data  (back_result),
        .i_pop   (pop),
        .o_data  (out_head),
        .o_full  (outq_full),
        .o_empty (empty)
    );

    assign o_event_kind      = out_head.event_kind;
    assign o_payload_byte    = out_head.payload_byte;
    assign o_last_of_message = out_head.last_of_message;
    assign o_frame_opcode    = out_head.frame_opcode;
    assign o_out_conn_id     = out_head.out_conn_id;

`ifndef SYNTHESIS
    // Both queue ports come out of reset idle
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    // Every result comes from a consumed byte
    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        outq_push |-> (cq_pop && !cq_empty))
        else $error("result produced without a consumed item");

    // The back part never pushes into a full result queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        outq_push |-> !outq_full)
        else $error("result queue overflow");

    // A truncated or header event never carries a payload byte
    a_event_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (outq_push && back_result.event_kind != EV_PAYLOAD) |->
            (back_result.payload_byte == 8'h00))
        else $error("event carries a payload byte");
`endif

endmodule
